FILE: rtl/ssa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants of the segregated storage allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

   localparam int DEF_POOL_PAGES  = 256;
   localparam int DEF_STACK_DEPTH = 64;

   localparam int CLASS_COUNT = 11;
   localparam int PAGE_BYTES  = 4096;
   localparam int ADDR_W      = 20;
   localparam int SIZE_W      = 16;
   localparam int OSIZE_W     = 13;
   localparam int CLASS_W     = 4;
   localparam int STATUS_W    = 3;
   localparam int KIND_W      = 2;
   localparam int NPAGE_W     = 9;
   localparam int CFG_W       = 9;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;

   localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

   localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REALLOC = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOREIGN   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 3'd3;
   localparam logic [STATUS_W-1:0] ST_STACK_FULL = 3'd4;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } sts_type;

   function automatic logic [OSIZE_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
      class_bytes = OSIZE_W'(4) << c;
   endfunction

endpackage

FILE: rtl/ssa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_ctrl
// Request sequencer: capture, table lookup, execute and hand off.
// ----------------------------------------------------------------------------
module ssa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  ssa_pkg::sts_type sts,
   output ssa_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      req_tready  = (state_ff == S_IDLE);
      cmd.capture = req_tready && req_tvalid;
      cmd.lookup  = (state_ff == S_LOOK);
      cmd.execute = (state_ff == S_EXEC) && !sts.rsp_busy;
      case (state_ff)
         S_IDLE:  state_in = cmd.capture ? S_LOOK : S_IDLE;
         S_LOOK:  state_in = S_EXEC;
         S_EXEC:  state_in = cmd.execute ? S_IDLE : S_EXEC;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/ssa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_dp
// Allocator datapath: page class table, class cursors, free stacks and
// the response register.
// ----------------------------------------------------------------------------
module ssa_dp #(
   parameter int POOL_PAGES  = ssa_pkg::DEF_POOL_PAGES,
   parameter int STACK_DEPTH = ssa_pkg::DEF_STACK_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ssa_pkg::cmd_type                 cmd,
   output ssa_pkg::sts_type                 sts,
   input  logic [ssa_pkg::KIND_W-1:0]       req_tuser,
   input  logic [ssa_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ssa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   input  logic [ssa_pkg::CFG_W-1:0]        csr_data
);

   localparam int NC    = ssa_pkg::CLASS_COUNT;
   localparam int AW    = ssa_pkg::ADDR_W;
   localparam int CW    = ssa_pkg::CLASS_W;
   localparam int PW    = $clog2(POOL_PAGES);
   localparam int SW    = $clog2(NC * STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int NPW   = ssa_pkg::NPAGE_W;

   logic [CW-1:0]     page_mem [POOL_PAGES];
   logic [AW-1:0]     stack_mem [NC * STACK_DEPTH];

   logic [ssa_pkg::CFG_W-1:0]  cfg_ff;
   logic [ssa_pkg::KIND_W-1:0] kind_ff;
   logic [AW-1:0]              baddr_ff;
   logic                       big_ff;
   logic [CW-1:0]              nc_ff;
   logic [CW-1:0]              page_rd_ff;
   logic [AW-1:0]              stack_rd_ff;
   logic [NPW-1:0]             next_page_ff;
   logic [NPW-1:0]             next_page_in;
   logic [NC-1:0]              cur_valid_ff;
   logic [NC-1:0]              cur_valid_in;
   logic [AW-1:0]              cursor_ff [NC];
   logic [AW-1:0]              cursor_in [NC];
   logic [CNT_W-1:0]           count_ff [NC];
   logic [CNT_W-1:0]           count_in [NC];
   logic                       rsp_valid_ff;
   logic [ssa_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [ssa_pkg::RSP_DATA_W-1:0] rsp_data_in;

   logic [ssa_pkg::SIZE_W-1:0] req_size;
   logic [AW-1:0]              req_addr;
   logic [CW-1:0]              req_class;
   logic [SW-1:0]              pop_idx;

   logic [7:0]       pg;
   logic             own_ok;
   logic [CW-1:0]    oc;
   logic             have_free;
   logic             need_page;
   logic             pool_empty;
   logic             take_ok;
   logic             do_take;
   logic             do_push;
   logic             push_full;
   logic [AW-1:0]    cur;
   logic [AW:0]      nxt;
   logic [AW-1:0]    take_addr;
   logic [CNT_W-1:0] cnt_pop [NC];
   logic [SW-1:0]    push_idx;
   logic [ssa_pkg::STATUS_W-1:0] st;
   logic [AW-1:0]    raddr;
   logic [ssa_pkg::OSIZE_W-1:0] osize;
   logic [CW-1:0]    rclass;

   assign req_size = req_tdata[15:0];
   assign req_addr = req_tdata[35:16];

   always_comb begin
      req_class = CW'(NC - 1);
      for (int c = NC - 1; c >= 0; c--) begin
         if (32'(req_size) <= (32'd4 << c)) begin
            req_class = CW'(c);
         end
      end
   end

   assign pop_idx = SW'(32'(nc_ff) * STACK_DEPTH) + SW'(count_ff[nc_ff] - CNT_W'(1));

   // execute stage
   always_comb begin
      pg         = baddr_ff[19:12];
      own_ok     = (32'(pg) < POOL_PAGES) && (NPW'(pg) < next_page_ff) &&
                   (32'(page_rd_ff) < NC);
      oc         = page_rd_ff;
      have_free  = (count_ff[nc_ff] != '0);
      need_page  = !have_free && !cur_valid_ff[nc_ff];
      pool_empty = (32'(next_page_ff) >= ((32'(cfg_ff) < POOL_PAGES) ?
                   32'(cfg_ff) : POOL_PAGES));
      take_ok    = !(need_page && pool_empty);
      cur        = cur_valid_ff[nc_ff] ? cursor_ff[nc_ff] : {next_page_ff[7:0], 12'b0};
      nxt        = {1'b0, cur} + (AW + 1)'(ssa_pkg::class_bytes(nc_ff));
      take_addr  = have_free ? stack_rd_ff : cur;

      st     = ssa_pkg::ST_OK;
      raddr  = '0;
      osize  = '0;
      rclass = '0;
      do_take = 1'b0;
      do_push = 1'b0;

      for (int c = 0; c < NC; c++) begin
         cnt_pop[c] = count_ff[c];
      end

      case (kind_ff)
         ssa_pkg::KIND_ALLOC: begin
            if (big_ff) begin
               st = ssa_pkg::ST_TOO_LARGE;
            end else if (!take_ok) begin
               st = ssa_pkg::ST_NO_MEMORY;
            end else begin
               do_take = 1'b1;
            end
         end
         ssa_pkg::KIND_FREE: begin
            if (!own_ok) begin
               st = ssa_pkg::ST_FOREIGN;
            end else begin
               do_push = 1'b1;
            end
         end
         ssa_pkg::KIND_REALLOC: begin
            if (!own_ok) begin
               st = ssa_pkg::ST_FOREIGN;
            end else if (big_ff) begin
               st    = ssa_pkg::ST_TOO_LARGE;
               osize = ssa_pkg::class_bytes(oc);
            end else if (!take_ok) begin
               st = ssa_pkg::ST_NO_MEMORY;
            end else begin
               do_take = 1'b1;
               do_push = 1'b1;
            end
         end
         default: begin
            st = ssa_pkg::ST_OK;
         end
      endcase

      if (do_take) begin
         raddr  = take_addr;
         rclass = nc_ff;
         if (have_free) begin
            cnt_pop[nc_ff] = count_ff[nc_ff] - CNT_W'(1);
         end
      end

      push_full = (32'(cnt_pop[oc]) >= STACK_DEPTH);
      push_idx  = SW'(32'(oc) * STACK_DEPTH) + SW'(cnt_pop[oc]);
      if (do_push) begin
         if (push_full) begin
            st = ssa_pkg::ST_STACK_FULL;
            if (kind_ff == ssa_pkg::KIND_REALLOC) begin
               osize = ssa_pkg::class_bytes(oc);
            end
         end else begin
            osize = ssa_pkg::class_bytes(oc);
         end
      end

      for (int c = 0; c < NC; c++) begin
         count_in[c]  = cnt_pop[c];
         cursor_in[c] = cursor_ff[c];
      end
      cur_valid_in = cur_valid_ff;
      next_page_in = next_page_ff;
      if (do_push && !push_full) begin
         count_in[oc] = cnt_pop[oc] + CNT_W'(1);
      end
      if (do_take && !have_free) begin
         if (need_page) begin
            next_page_in = next_page_ff + NPW'(1);
         end
         cur_valid_in[nc_ff] = (nxt[11:0] != 12'b0);
         cursor_in[nc_ff]    = nxt[AW-1:0];
      end

      rsp_data_in = {rclass, osize, raddr, st};
   end

   assign sts.rsp_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= ssa_pkg::CFG_RESET;
         next_page_ff <= '0;
         cur_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NC; c++) begin
            count_ff[c] <= '0;
         end
      end else begin
         if (csr_valid) begin
            cfg_ff <= csr_data;
         end
         if (cmd.execute) begin
            next_page_ff <= next_page_in;
            cur_valid_ff <= cur_valid_in;
            for (int c = 0; c < NC; c++) begin
               count_ff[c] <= count_in[c];
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req_tuser;
         baddr_ff   <= req_addr;
         big_ff     <= (32'(req_size) > ssa_pkg::PAGE_BYTES);
         nc_ff      <= req_class;
         page_rd_ff <= page_mem[PW'(req_addr[19:12])];
      end
      if (cmd.lookup) begin
         stack_rd_ff <= stack_mem[pop_idx];
      end
      if (cmd.execute) begin
         rsp_data_ff <= rsp_data_in;
         for (int c = 0; c < NC; c++) begin
            cursor_ff[c] <= cursor_in[c];
         end
         if (do_take && need_page) begin
            page_mem[PW'(next_page_ff)] <= nc_ff;
         end
         if (do_push && !push_full) begin
            stack_mem[push_idx] <= baddr_ff;
         end
      end
   end

endmodule

FILE: rtl/segregated_storage_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segregated_storage_allocator
// Page pool allocator with eleven power-of-two size classes (4 to 4096 bytes).
// Each request runs in three steps: page class table read, free stack read,
// then update and response; the table and stack memories have registered
// reads. A new request is taken while the last response still waits.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module segregated_storage_allocator #(
   parameter int POOL_PAGES  = ssa_pkg::DEF_POOL_PAGES,
   parameter int STACK_DEPTH = ssa_pkg::DEF_STACK_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ssa_pkg::REQ_DATA_W-1:0] req_tdata,  // request_size, block_address
   input  logic [ssa_pkg::KIND_W-1:0]     req_tuser,  // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ssa_pkg::RSP_DATA_W-1:0] rsp_tdata,  // status, result_address,
                                                      // old_size, size_class
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ssa_pkg::CFG_W-1:0]      csr_data    // pool_pages_in_use
);

   ssa_pkg::cmd_type cmd;
   ssa_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   ssa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ssa_dp #(
      .POOL_PAGES  (POOL_PAGES),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data)
   );

endmodule
